// ===== design/gtld_pkg.sv =====
// gtld_pkg: types and constants shared by the GPS track log decimator.
// Holds the sequencer state type, register indexes, angle and CORDIC constants.
// No dependencies.
`default_nettype none

package gtld_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MOD1,
    ST_MOD2,
    ST_RMUL,
    ST_QEST,
    ST_QMUL,
    ST_QFIX,
    ST_CINIT,
    ST_CITER,
    ST_CW,
    ST_CP1,
    ST_CP2,
    ST_CP3,
    ST_CSTORE,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_CMP,
    ST_FIN
  } state_e;

  localparam logic [2:0] REG_WARN_EN     = 3'd0;
  localparam logic [2:0] REG_SPEED_LIMIT = 3'd1;
  localparam logic [2:0] REG_LOG_EN      = 3'd2;
  localparam logic [2:0] REG_BEEP_EN     = 3'd3;
  localparam logic [2:0] REG_DENSITY     = 3'd4;

  localparam logic [1:0] DENS_LOW  = 2'd0;
  localparam logic [1:0] DENS_MED  = 2'd1;
  localparam logic [1:0] DENS_HIGH = 2'd2;

  localparam logic [31:0] ALARM_GAP   = 32'd15;
  localparam logic [15:0] SPEED_BAND1 = 16'd1280;
  localparam logic [15:0] SPEED_BAND2 = 16'd5120;

  // 360 degrees in 1e-7 degree units, and half of it for rounding
  localparam logic [31:0] TURN_UNITS = 32'd3600000000;
  localparam logic [31:0] HALF_TURN  = 32'd1800000000;
  // floor(2^64 / TURN_UNITS)
  localparam logic signed [33:0] TURN_RECIP = 34'sd5124095576;

  localparam logic signed [33:0] CORDIC_K   = 34'sd652032874;
  localparam logic signed [33:0] TWO_PI_Q12 = 34'sd25736;

  function automatic logic [29:0] atan_lut(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== design/gps_track_log_decimator.sv =====
// gps_track_log_decimator: top level, sequencer and shared datapath.
// Depends on gtld_pkg.
// Uses one multiplier and one CORDIC shift-add stage over many cycles.
`default_nettype none

// One fix is taken at a time; in_ready_o is high only while the sequencer is idle.
// The first fix after reset is kept at once and goes straight to the final state. Every
// later fix runs four angle conversions (modulo 360 degrees, then a reciprocal multiply, a
// back multiply and a one-step correction), five CORDIC sine/cosine passes of
// TRIG_ITERATIONS steps plus setup, residual correction and store, and the products and
// compare on the single multiplier. Its result becomes valid in the same cycle as the
// sequencer returns to idle, so the next fix can be taken while that result is shown.
// A finished result sits in an output register, and the block returns to idle as soon
// as that register is free.

module gps_track_log_decimator #(
  parameter int EARTH_RADIUS_M  = 6371000,
  parameter int TRIG_ITERATIONS = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic        [4:0]  paddr,
  input  wire logic        [31:0] pwdata,
  output      logic        [31:0] prdata,
  output      logic               pready,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic signed [30:0] fix_latitude_i,
  input  wire logic signed [31:0] fix_longitude_i,
  input  wire logic        [15:0] fix_speed_i,
  input  wire logic        [31:0] now_seconds_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic               fix_kept_o,
  output      logic               write_log_o,
  output      logic               beep_o,
  output      logic               speed_alarm_o
);
  import gtld_pkg::*;

  localparam int ITERS = (TRIG_ITERATIONS > 32) ? 32 : TRIG_ITERATIONS;
  localparam logic [4:0] ITER_LAST = 5'(ITERS - 1);

  localparam logic [63:0] DEN_RAW = (64'd3373259426 * 64'(EARTH_RADIUS_M)) >> 20;
  localparam logic [63:0] DEN     = (DEN_RAW == 64'd0) ? 64'd1 : DEN_RAW;
  localparam logic [63:0] HB_10   = (64'd10 << 40) / DEN;
  localparam logic [63:0] HB_20   = (64'd20 << 40) / DEN;
  localparam logic [63:0] HB_25   = (64'd25 << 40) / DEN;
  localparam logic [63:0] HB_40   = (64'd40 << 40) / DEN;
  localparam logic [63:0] HB_50   = (64'd50 << 40) / DEN;
  localparam logic [63:0] HB_100  = (64'd100 << 40) / DEN;
  localparam logic [63:0] HB_200  = (64'd200 << 40) / DEN;

  state_e state_q, state_d;

  // configuration
  logic        warn_en_q, log_en_q, beep_en_q;
  logic [15:0] speed_limit_q;
  logic [1:0]  density_q;
  logic        cfg_wr;

  // control state
  logic        first_q;
  logic [31:0] last_alarm_q;
  logic        out_valid_q;
  logic        alarm_q, kept_q;
  logic        out_kept_q, out_log_q, out_beep_q, out_alarm_q;
  logic [2:0]  k_q;
  logic [4:0]  it_q;

  // payload
  logic signed [30:0] lat_q;
  logic signed [31:0] lon_q;
  logic        [15:0] speed_q;
  logic signed [31:0] ref_lat_q, ref_lon_q;

  // datapath
  logic signed [33:0] a_q;
  logic        [31:0] r_q, ang_q;
  logic signed [33:0] x_q, y_q, w_q;
  logic signed [32:0] z_q;
  logic signed [63:0] p_q, h_q;
  logic signed [33:0] ca_q, cb_q, s1_q, s2_q, hs_q, t_q;

  logic signed [33:0] src_a;
  logic        [64:0] est_sum;
  logic        [31:0] est;
  logic        [63:0] num, rem;
  logic signed [33:0] xs, ys;
  logic signed [32:0] at_s;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  logic signed [63:0] p_sh44, p_sh30;
  logic signed [33:0] cq, sq;
  logic        [63:0] hb_sel;
  logic        [1:0]  band;
  logic               out_free, accept;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[4:2])
      REG_WARN_EN:     prdata = {31'd0, warn_en_q};
      REG_SPEED_LIMIT: prdata = {16'd0, speed_limit_q};
      REG_LOG_EN:      prdata = {31'd0, log_en_q};
      REG_BEEP_EN:     prdata = {31'd0, beep_en_q};
      REG_DENSITY:     prdata = {30'd0, density_q};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warn_en_q     <= 1'b0;
      speed_limit_q <= 16'd0;
      log_en_q      <= 1'b0;
      beep_en_q     <= 1'b0;
      density_q     <= DENS_HIGH;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_WARN_EN:     warn_en_q     <= pwdata[0];
        REG_SPEED_LIMIT: speed_limit_q <= pwdata[15:0];
        REG_LOG_EN:      log_en_q      <= pwdata[0];
        REG_BEEP_EN:     beep_en_q     <= pwdata[0];
        REG_DENSITY:     density_q     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign accept   = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = first_q ? ST_FIN : ST_LOAD;
      end
      ST_LOAD:  state_d = ST_MOD1;
      ST_MOD1:  state_d = ST_MOD2;
      ST_MOD2:  state_d = ST_RMUL;
      ST_RMUL:  state_d = ST_QEST;
      ST_QEST:  state_d = ST_QMUL;
      ST_QMUL:  state_d = ST_QFIX;
      ST_QFIX:  state_d = ST_CINIT;
      ST_CINIT: state_d = ST_CITER;
      ST_CITER: if (it_q == ITER_LAST) state_d = ST_CW;
      ST_CW:    state_d = ST_CP1;
      ST_CP1:   state_d = ST_CP2;
      ST_CP2:   state_d = ST_CP3;
      ST_CP3:   state_d = ST_CSTORE;
      ST_CSTORE: begin
        if (k_q == 3'd4)      state_d = ST_M1;
        else if (k_q == 3'd3) state_d = ST_CINIT;
        else                  state_d = ST_LOAD;
      end
      ST_M1:  state_d = ST_M2;
      ST_M2:  state_d = ST_M3;
      ST_M3:  state_d = ST_M4;
      ST_M4:  state_d = ST_M5;
      ST_M5:  state_d = ST_CMP;
      ST_CMP: state_d = ST_FIN;
      ST_FIN: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // angle source for the conversion in progress
  always_comb begin
    case (k_q)
      3'd0:    src_a = {{3{lat_q[30]}}, lat_q};
      3'd1:    src_a = {{2{ref_lat_q[31]}}, ref_lat_q};
      3'd2:    src_a = {{3{lat_q[30]}}, lat_q} - {{2{ref_lat_q[31]}}, ref_lat_q};
      default: src_a = {{2{lon_q[31]}}, lon_q} - {{2{ref_lon_q[31]}}, ref_lon_q};
    endcase
  end

  // binary angle: estimate by reciprocal, then at most one step up
  assign est_sum = {1'b0, p_q} + ((k_q < 3'd2) ? 65'd2147483648 : 65'd4294967296);
  assign est     = (k_q < 3'd2) ? est_sum[63:32] : est_sum[64:33];
  assign num     = (k_q < 3'd2) ? ({r_q, 32'd0} + {32'd0, HALF_TURN}) :
                                  ({1'b0, r_q, 31'd0} + {32'd0, HALF_TURN});
  assign rem     = num - $unsigned(p_q);

  assign xs   = x_q >>> it_q;
  assign ys   = y_q >>> it_q;
  assign at_s = $signed({3'b000, atan_lut(it_q)});

  always_comb begin
    mul_a = ca_q;
    mul_b = cb_q;
    case (state_q)
      ST_RMUL: begin
        mul_a = $signed({2'b00, r_q});
        mul_b = TURN_RECIP;
      end
      ST_QMUL: begin
        mul_a = $signed({2'b00, ang_q});
        mul_b = $signed({2'b00, TURN_UNITS});
      end
      ST_CW: begin
        mul_a = {z_q[32], z_q};
        mul_b = TWO_PI_Q12;
      end
      ST_CP1: begin
        mul_a = y_q;
        mul_b = w_q;
      end
      ST_CP2: begin
        mul_a = x_q;
        mul_b = w_q;
      end
      ST_M2: begin
        mul_a = p_sh30[33:0];
        mul_b = s2_q;
      end
      ST_M3: begin
        mul_a = s1_q;
        mul_b = s1_q;
      end
      ST_M4: begin
        mul_a = t_q;
        mul_b = s2_q;
      end
      ST_M5: begin
        mul_a = hs_q;
        mul_b = hs_q;
      end
      default: ;
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  assign p_sh44 = p_q >>> 44;
  assign p_sh30 = p_q >>> 30;

  always_comb begin
    case (ang_q[31:30])
      2'd0: begin
        cq = x_q;
        sq = y_q;
      end
      2'd1: begin
        cq = -y_q;
        sq = x_q;
      end
      2'd2: begin
        cq = -x_q;
        sq = -y_q;
      end
      default: begin
        cq = y_q;
        sq = -x_q;
      end
    endcase
  end

  always_comb begin
    if (speed_q < SPEED_BAND1)      band = 2'd0;
    else if (speed_q < SPEED_BAND2) band = 2'd1;
    else                            band = 2'd2;
    case ({band, density_q})
      {2'd0, DENS_LOW}: hb_sel = HB_40;
      {2'd0, DENS_MED}: hb_sel = HB_20;
      {2'd1, DENS_LOW}: hb_sel = HB_100;
      {2'd1, DENS_MED}: hb_sel = HB_50;
      {2'd2, DENS_LOW}: hb_sel = HB_200;
      {2'd2, DENS_MED}: hb_sel = HB_100;
      default: begin
        if (band == 2'd0)      hb_sel = HB_10;
        else if (band == 2'd1) hb_sel = HB_25;
        else                   hb_sel = HB_50;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q      <= 1'b1;
      last_alarm_q <= 32'd0;
      out_valid_q  <= 1'b0;
      alarm_q      <= 1'b0;
      kept_q       <= 1'b0;
      k_q          <= 3'd0;
      it_q         <= 5'd0;
    end else begin
      if (accept) begin
        kept_q  <= first_q;
        first_q <= 1'b0;
        k_q     <= 3'd0;
        alarm_q <= 1'b0;
        if (warn_en_q && (fix_speed_i > speed_limit_q) &&
            ((now_seconds_i - last_alarm_q) > ALARM_GAP)) begin
          alarm_q      <= 1'b1;
          last_alarm_q <= now_seconds_i;
        end
      end
      case (state_q)
        ST_CINIT:  it_q <= 5'd0;
        ST_CITER:  it_q <= it_q + 5'd1;
        ST_CSTORE: k_q <= k_q + 3'd1;
        ST_CMP:    kept_q <= h_q > p_q;
        default: ;
      endcase
      if (state_q == ST_FIN && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i)              out_valid_q <= 1'b0;
    end
  end

  // payload and datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      lat_q   <= fix_latitude_i;
      lon_q   <= fix_longitude_i;
      speed_q <= fix_speed_i;
    end
    case (state_q)
      ST_LOAD: a_q <= src_a;
      ST_MOD1: if (a_q < 34'sd0) a_q <= a_q + $signed({2'b00, TURN_UNITS});
      ST_MOD2: begin
        if (a_q < 34'sd0) begin
          r_q <= 32'(a_q + $signed({2'b00, TURN_UNITS}));
        end else if (a_q >= $signed({2'b00, TURN_UNITS})) begin
          r_q <= 32'(a_q - $signed({2'b00, TURN_UNITS}));
        end else begin
          r_q <= a_q[31:0];
        end
      end
      ST_RMUL: p_q <= mul_p[63:0];
      ST_QEST: ang_q <= est;
      ST_QMUL: p_q <= mul_p[63:0];
      ST_QFIX: if (rem >= {32'd0, TURN_UNITS}) ang_q <= ang_q + 32'd1;
      ST_CINIT: begin
        x_q <= CORDIC_K;
        y_q <= 34'sd0;
        z_q <= $signed({3'b000, ang_q[29:0]});
      end
      ST_CITER: begin
        if (z_q >= 33'sd0) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - at_s;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + at_s;
        end
      end
      ST_CW:  w_q <= mul_p[33:0];
      ST_CP1: p_q <= mul_p[63:0];
      ST_CP2: begin
        x_q <= x_q - p_sh44[33:0];
        p_q <= mul_p[63:0];
      end
      ST_CP3: y_q <= y_q + p_sh44[33:0];
      ST_CSTORE: begin
        case (k_q)
          3'd0:    ca_q <= cq;
          3'd1:    cb_q <= cq;
          3'd2:    s1_q <= sq;
          3'd3:    s2_q <= sq;
          default: hs_q <= sq;
        endcase
        if (k_q == 3'd3) ang_q <= hb_sel[31:0];
      end
      ST_M1: p_q <= mul_p[63:0];
      ST_M2: p_q <= mul_p[63:0];
      ST_M3: begin
        t_q <= p_sh30[33:0];
        p_q <= mul_p[63:0];
      end
      ST_M4: begin
        h_q <= p_q;
        p_q <= mul_p[63:0];
      end
      ST_M5: begin
        h_q <= h_q + p_q;
        p_q <= mul_p[63:0];
      end
      ST_FIN: begin
        if (out_free) begin
          out_kept_q  <= kept_q;
          out_log_q   <= kept_q & log_en_q;
          out_beep_q  <= kept_q & log_en_q & beep_en_q;
          out_alarm_q <= alarm_q;
          if (kept_q) begin
            ref_lat_q <= {lat_q[30], lat_q};
            ref_lon_q <= lon_q;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign fix_kept_o    = out_kept_q;
  assign write_log_o   = out_log_q;
  assign beep_o        = out_beep_q;
  assign speed_alarm_o = out_alarm_q;

endmodule

`default_nettype wire

// ===== test/tb_gps_track_log_decimator.sv =====
// tb_gps_track_log_decimator: self-checking testbench for the GPS track log decimator.
// Predicts keep/log/beep/alarm per fix with an integer CORDIC model and checks every result.
// Depends on gtld_pkg and gps_track_log_decimator.
`timescale 1ns / 1ps

module tb_gps_track_log_decimator;
  import gtld_pkg::*;

  localparam int TRIG_N = 24;
  localparam longint EARTH_R = 6371000;
  localparam longint TURN = 64'sd3600000000;
  localparam logic [1:0] DENS_THREE = 2'd3;

  typedef struct packed {
    logic kept;
    logic log_w;
    logic beep;
    logic alarm;
  } fix_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [30:0] fix_latitude_i = '0;
  logic signed [31:0] fix_longitude_i = '0;
  logic [15:0] fix_speed_i = '0;
  logic [31:0] now_seconds_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic fix_kept_o, write_log_o, beep_o, speed_alarm_o;

  // model state
  logic warn_en, log_en, beep_en;
  logic [15:0] spd_limit;
  logic [1:0] dens;
  logic [31:0] ref_lat, ref_lon, last_alarm;
  logic first_pending;
  fix_res_t expected_q[$];
  int errors = 0;
  bit quiet = 0;
  int hold_req = 0, hold_seen = 0, hold_left = 0;
  logic [31:0] clock_s = 0;

  longint atan_tab[32] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};

  gps_track_log_decimator u_dut (.*);

  always #2 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [31:0] to_bin_angle(longint a, int sh);
    longint m;
    logic [63:0] u;
    m = a % TURN;
    if (m < 0) m += TURN;
    u = m;
    u = ((u << sh) + 64'd1800000000) / 64'd3600000000;
    return u[31:0];
  endfunction

  task automatic cordic_sincos(input logic [31:0] ang, output longint c, output longint s);
    longint x, y, z, nx, ny, w;
    x = 652032874;
    y = 0;
    z = ang[29:0];
    for (int i = 0; i < TRIG_N; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_tab[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += atan_tab[i];
      end
      x = nx; y = ny;
    end
    w = z * 25736;
    nx = x - ((y * w) >>> 44);
    ny = y + ((x * w) >>> 44);
    case (ang[31:30])
      2'd0: begin c = nx; s = ny; end
      2'd1: begin c = -ny; s = nx; end
      2'd2: begin c = -nx; s = -ny; end
      default: begin c = ny; s = -nx; end
    endcase
  endtask

  task automatic predict_fix(input logic signed [30:0] lat_in, input logic signed [31:0] lon_in,
                             input logic [15:0] spd, input logic [31:0] now);
    longint lat, lon, rlat, rlon, ca, cb, t, s1, s2, h, hs, thr, mind;
    logic [63:0] den, hb;
    fix_res_t r;
    lat = lat_in;
    lon = lon_in;
    r = '0;
    if (warn_en && spd > spd_limit && (now - last_alarm) > ALARM_GAP) begin
      r.alarm = 1'b1;
      last_alarm = now;
    end
    if (first_pending) begin
      r.kept = 1'b1;
      first_pending = 1'b0;
    end else begin
      rlat = $signed(ref_lat);
      rlon = $signed(ref_lon);
      cordic_sincos(to_bin_angle(lat, 32), ca, t);
      cordic_sincos(to_bin_angle(rlat, 32), cb, t);
      cordic_sincos(to_bin_angle(lat - rlat, 31), t, s1);
      cordic_sincos(to_bin_angle(lon - rlon, 31), t, s2);
      t = (ca * cb) >>> 30;
      t = (t * s2) >>> 30;
      h = s1 * s1 + t * s2;
      mind = (spd < SPEED_BAND1) ? 10 : (spd < SPEED_BAND2) ? 25 : 50;
      if (dens == DENS_LOW) mind *= 4;
      else if (dens == DENS_MED) mind *= 2;
      den = (64'd3373259426 * EARTH_R) >> 20;
      hb = (mind << 40) / den;
      cordic_sincos(hb[31:0], t, hs);
      thr = hs * hs;
      if (h > thr) r.kept = 1'b1;
    end
    if (r.kept) begin
      ref_lat = 32'(lat);
      ref_lon = 32'(lon);
    end
    r.log_w = r.kept & log_en;
    r.beep = r.log_w & beep_en;
    expected_q.push_back(r);
  endtask

  // receiver: random stalls, quiet stretches, and long hold-offs on request
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 18);
    end
  end

  always @(posedge clk_i) begin
    fix_res_t got, exp_r;
    if (out_valid_o && out_ready_i) begin
      got = '{fix_kept_o, write_log_o, beep_o, speed_alarm_o};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %b", $time, got);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          $display("%0t: mismatch kept/log/beep/alarm expected %b actual %b",
                   $time, exp_r, got);
          errors++;
        end
      end
    end
  end

  task automatic send_fix(input logic signed [30:0] lat, input logic signed [31:0] lon,
                          input logic [15:0] spd, input logic [31:0] now);
    @(negedge clk_i);
    while (!quiet && $urandom_range(0, 99) < 18) @(negedge clk_i);
    fix_latitude_i <= lat;
    fix_longitude_i <= lon;
    fix_speed_i <= spd;
    now_seconds_i <= now;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_fix(lat, lon, spd, now);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_WARN_EN:     warn_en = val[0];
      REG_SPEED_LIMIT: spd_limit = val[15:0];
      REG_LOG_EN:      log_en = val[0];
      REG_BEEP_EN:     beep_en = val[0];
      default:         dens = val[1:0];
    endcase
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic configure(logic w, logic [15:0] lim, logic l, logic b, logic [1:0] d);
    drain();
    apb_write(REG_WARN_EN, {31'd0, w});
    apb_write(REG_SPEED_LIMIT, {16'd0, lim});
    apb_write(REG_LOG_EN, {31'd0, l});
    apb_write(REG_BEEP_EN, {31'd0, b});
    apb_write(REG_DENSITY, {30'd0, d});
  endtask

  // fix near the current reference, or anywhere
  task automatic random_fix(int n);
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic [15:0] spd;
    int sel, span;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      span = ($urandom_range(0, 3) == 0) ? 40000 : 4000;
      if (sel < 75) begin
        lat = 31'($signed(ref_lat) + $signed($urandom_range(0, 2 * span)) - span);
        lon = 32'($signed(ref_lon) + $signed($urandom_range(0, 2 * span)) - span);
      end else if (sel < 88) begin
        lat = 31'($signed($urandom_range(0, 1800000000)) - 900000000);
        lon = $urandom_range(0, 32'd3600000000) - 32'd1800000000;
      end else begin
        lat = 31'($urandom);
        lon = $urandom;
      end
      case ($urandom_range(0, 3))
        0: spd = 16'($urandom_range(0, 1279));
        1: spd = 16'($urandom_range(1280, 5119));
        2: spd = 16'($urandom_range(5120, 65535));
        default: spd = 16'($urandom);
      endcase
      if ($urandom_range(0, 19) == 0) clock_s = $urandom;
      else clock_s += $urandom_range(0, 20);
      send_fix(lat, lon, spd, clock_s);
    end
  endtask

  task automatic test_directed;
    configure(1'b1, 16'd0, 1'b1, 1'b1, DENS_HIGH);
    send_fix(31'sd0, 32'sd0, 16'd1, 32'd15);          // first kept, gap not exceeded
    send_fix(31'sd500, 32'sd0, 16'd1, 32'd16);        // alarm at gap 16
    send_fix(31'sd1000, 32'sd0, 16'd0, 32'd100);      // speed equal to limit
    send_fix(-31'sd1073741824, -32'sd2147483648, 16'hFFFF, 32'hFFFF_FFF8);
    send_fix(31'sd1073741823, 32'sd2147483647, 16'hFFFF, 32'd7);   // wrapped time
    send_fix(31'sd900000000, 32'sd1800000000, 16'd1279, 32'd30);
    send_fix(31'sd900000000, -32'sd1800000000, 16'd1280, 32'd60);  // same point
    send_fix(-31'sd900000000, 32'sd0, 16'd5119, 32'd90);
    send_fix(-31'sd899999000, 32'sd0, 16'd5120, 32'd91);
    configure(1'b1, 16'hFFFF, 1'b0, 1'b1, DENS_LOW);
    send_fix(-31'sd899990000, 32'sd0, 16'hFFFF, 32'd200);
    send_fix(-31'sd899980000, 32'sd300, 16'd100, 32'd300);
    configure(1'b0, 16'd100, 1'b1, 1'b0, DENS_MED);
    send_fix(-31'sd899975000, 32'sd300, 16'd200, 32'd400);
    send_fix(-31'sd899974000, 32'sd300, 16'd6000, 32'd500);
    configure(1'b1, 16'd2000, 1'b1, 1'b1, DENS_THREE);
    send_fix(-31'sd899973500, 32'sd300, 16'd3000, 32'd600);
    send_fix(-31'sd899972000, 32'sd400, 16'd1000, 32'd610);
    send_fix(31'sd0, 32'sd0, 16'd100, 32'd611);
  endtask

  task automatic test_backpressure;
    drain();
    hold_req++;
    random_fix(6);
  endtask

  task automatic test_random;
    for (int p = 0; p < 10; p++) begin
      configure(1'($urandom_range(0, 1)),
                ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                2'($urandom_range(0, 3)));
      quiet = (p == 4);
      random_fix(125);
    end
    quiet = 0;
  endtask

  initial begin
    warn_en = 0; spd_limit = 0; log_en = 0; beep_en = 0; dens = DENS_HIGH;
    ref_lat = 0; ref_lon = 0; last_alarm = 0; first_pending = 1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    drain();
    repeat (400) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/gtld_pkg.sv
design/gps_track_log_decimator.sv
test/tb_gps_track_log_decimator.sv
